// ===== src/bfre_pkg.sv =====
// Shared types, widths and the reciprocal table of the row box filter.
package bfre_pkg;

    localparam int PIX_W       = 8;
    localparam int RAD_W       = 5;
    localparam int SUM_W       = 14;   // holds 63 * 255 + 31
    localparam int ROWPOS_W    = 6;
    localparam int ROWPOS_MAX  = 63;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 20;   // SUM_W + 6 bits of divisor: exact floor for any sum
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int OUTQ_DEPTH  = 8;
    localparam int OUTQ_PTR_W  = 3;
    localparam int OUTQ_CNT_W  = 4;
    localparam int CFG_ADDR_W  = 3;

    localparam logic CFG_IDX_RADIUS = 1'b0;

    // ceil(2^20 / (2r+1)) for r = 0..31
    localparam logic [RECIP_W-1:0] RECIP_TABLE [32] = '{
        21'd1048576, 21'd349526, 21'd209716, 21'd149797,
        21'd116509,  21'd95326,  21'd80660,  21'd69906,
        21'd61681,   21'd55189,  21'd49933,  21'd45591,
        21'd41944,   21'd38837,  21'd36158,  21'd33826,
        21'd31776,   21'd29960,  21'd28340,  21'd26887,
        21'd25576,   21'd24386,  21'd23302,  21'd22311,
        21'd21400,   21'd20561,  21'd19785,  21'd19066,
        21'd18397,   21'd17773,  21'd17190,  21'd16645
    };

    typedef struct packed {
        logic fill;    // load the broadcast pixel (row start)
        logic shift;   // take the neighbor's pixel
        logic entry;   // this cell is the window head: take the broadcast pixel on shift
    } cell_ctrl_t;

endpackage

// ===== src/bfre_cell.sv =====
// One delay-line cell: holds a pixel and passes it to the next cell.
module bfre_cell (
    input  logic                      aclk,
    input  bfre_pkg::cell_ctrl_t      ctrl,
    input  logic [bfre_pkg::PIX_W-1:0] bcast_pix,
    input  logic [bfre_pkg::PIX_W-1:0] nbr_pix,
    output logic [bfre_pkg::PIX_W-1:0] pix
);

    logic [bfre_pkg::PIX_W-1:0] pix_reg;
    logic [bfre_pkg::PIX_W-1:0] pix_next;

    always_comb begin
        pix_next = pix_reg;
        if (ctrl.fill) begin
            pix_next = bcast_pix;
        end else if (ctrl.shift) begin
            pix_next = ctrl.entry ? bcast_pix : nbr_pix;
        end
    end

    always_ff @(posedge aclk) begin
        pix_reg <= pix_next;
    end

    assign pix = pix_reg;

endmodule

// ===== src/bfre_mean.sv =====
// Two-stage rounded mean: (sum + r) times reciprocal of 2r+1, then take the quotient.
module bfre_mean (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_valid,
    input  logic                       in_last,
    input  logic [bfre_pkg::SUM_W-1:0] in_sum,
    input  logic [bfre_pkg::RAD_W-1:0] radius,
    output logic                       out_valid,
    output logic                       out_last,
    output logic [bfre_pkg::PIX_W-1:0] out_mean
);

    logic                          va_reg,  va_next;
    logic                          vb_reg,  vb_next;
    logic                          la_reg,  lb_reg;
    logic [bfre_pkg::SUM_W-1:0]    num_reg, num_next;
    logic [bfre_pkg::RECIP_W-1:0]  rc_reg,  rc_next;
    logic [bfre_pkg::PIX_W-1:0]    q_reg,   q_next;
    logic [bfre_pkg::PROD_W-1:0]   prod;

    always_comb begin
        va_next  = in_valid;
        vb_next  = va_reg;
        num_next = in_sum + bfre_pkg::SUM_W'(radius);
        rc_next  = bfre_pkg::RECIP_TABLE[radius];
        prod     = bfre_pkg::PROD_W'(num_reg) * bfre_pkg::PROD_W'(rc_reg);
        q_next   = prod[bfre_pkg::RECIP_SHIFT +: bfre_pkg::PIX_W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end else begin
            va_reg <= va_next;
            vb_reg <= vb_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg <= num_next;
        rc_reg  <= rc_next;
        la_reg  <= in_last;
        q_reg   <= q_next;
        lb_reg  <= la_reg;
    end

    assign out_valid = vb_reg;
    assign out_last  = lb_reg;
    assign out_mean  = q_reg;

endmodule

// ===== src/box_filter_row_edge_replicate_top.sv =====
// Top level of the streaming row box filter with edge replication.
//
//  channel   | dir | beat                               | accepted when
//  ----------+-----+------------------------------------+------------------------------
//  s_        | in  | tdata[7:0] pixel_in, tlast row end | s_tvalid & s_tready
//  m_        | out | tdata[7:0] pixel_out, tlast row end| m_tvalid & m_tready
//  APB       | in  | radius at byte address 0           | psel & penable & pwrite & pready
//
// One beat per cycle inside a row. A last-of-row beat is followed by r flush
// shifts of the cell chain with s_tready low. A result reaches m_tvalid
// through the sum register, the two-stage mean pipeline and then an 8-entry
// output queue; s_tready and the flush shifts also stop while 8 results are
// outstanding, which is what m_tready stalls throttle.
// Reset (synchronous, aresetn low) sets radius to 1 and starts a new row.
module box_filter_row_edge_replicate_top #(
    parameter int MAX_RADIUS = 31
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] pixel_in
    input  logic                              s_tlast,   // last_in_row
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [7:0]                        m_tdata,   // [7:0] pixel_out
    output logic                              m_tlast,   // last_out
    // configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bfre_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int DEPTH = 2 * MAX_RADIUS + 1;          // cells in the chain
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [bfre_pkg::RAD_W-1:0] MAX_R = bfre_pkg::RAD_W'(MAX_RADIUS);

    typedef enum logic [1:0] {
        ST_IDLE  = 2'b01,
        ST_FLUSH = 2'b10
    } state_t;

    localparam int RAD_PAD = bfre_pkg::ROWPOS_W + 1;   // width of n + k

    // ---------------------------------------------------------------- registers
    state_t                               state_reg,   state_next;
    logic [bfre_pkg::RAD_W-1:0]           radius_reg,  radius_next;
    logic [bfre_pkg::ROWPOS_W-1:0]        n_reg,       n_next;      // pixels seen in row
    logic [bfre_pkg::ROWPOS_W-1:0]        nh_reg,      nh_next;     // n held for flush
    logic [bfre_pkg::RAD_W-1:0]           k_reg,       k_next;      // flush step
    logic [bfre_pkg::PIX_W-1:0]           hold_reg,    hold_next;   // last pixel, replicated
    logic [bfre_pkg::SUM_W-1:0]           sum_reg,     sum_next;
    logic                                 v0_reg,      v0_next;
    logic                                 l0_reg,      l0_next;
    logic [bfre_pkg::OUTQ_CNT_W-1:0]      pend_reg,    pend_next;   // results owed
    logic [bfre_pkg::OUTQ_CNT_W-1:0]      qcnt_reg,    qcnt_next;
    logic [bfre_pkg::OUTQ_PTR_W-1:0]      wptr_reg,    wptr_next;
    logic [bfre_pkg::OUTQ_PTR_W-1:0]      rptr_reg,    rptr_next;
    logic [bfre_pkg::PIX_W-1:0]           qpix_reg [bfre_pkg::OUTQ_DEPTH];
    logic                                 qlast_reg [bfre_pkg::OUTQ_DEPTH];

    // ---------------------------------------------------------------- event decode
    logic [bfre_pkg::RAD_W-1:0]           ar;           // active radius
    logic [bfre_pkg::RAD_W:0]             win_len;      // 2r+1
    logic                                 acc, flush_go, ev_valid, ev_fill, ev_emit, ev_last;
    logic                                 cfg_wr, room, pop;
    logic [bfre_pkg::PIX_W-1:0]           ev_pix;
    logic [IDX_W-1:0]                     entry_idx;
    logic [bfre_pkg::PIX_W-1:0]           cell_pix [DEPTH];
    logic                                 mean_valid, mean_last;
    logic [bfre_pkg::PIX_W-1:0]           mean_pix;

    assign ar        = (radius_reg > MAX_R) ? MAX_R : radius_reg;
    assign win_len   = {ar, 1'b1};
    assign entry_idx = IDX_W'(DEPTH - 1) - IDX_W'({ar, 1'b0});

    assign room      = pend_reg < bfre_pkg::OUTQ_CNT_W'(bfre_pkg::OUTQ_DEPTH);
    assign s_tready  = (state_reg == ST_IDLE) && room;
    assign acc       = s_tvalid && s_tready;
    assign flush_go  = (state_reg == ST_FLUSH) && room;
    assign ev_valid  = acc || flush_go;
    assign ev_pix    = acc ? s_tdata[bfre_pkg::PIX_W-1:0] : hold_reg;
    assign ev_fill   = acc && (n_reg == '0);
    assign pop       = m_tvalid && m_tready;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready && (paddr[2] == bfre_pkg::CFG_IDX_RADIUS);
    assign prdata    = (paddr[2] == bfre_pkg::CFG_IDX_RADIUS) ?
                       32'(radius_reg) : 32'd0;

    always_comb begin
        if (acc) begin
            ev_emit = n_reg >= bfre_pkg::ROWPOS_W'(ar);
            ev_last = s_tlast && (ar == '0);
        end else begin
            ev_emit = (RAD_PAD'(nh_reg) + RAD_PAD'(k_reg)) >= RAD_PAD'(ar);
            ev_last = (k_reg == ar);
        end
        ev_emit = ev_emit && ev_valid;
    end

    // ---------------------------------------------------------------- cell chain
    // Oldest pixel sits in the far cell; a new pixel enters at DEPTH-1-2r so the
    // outgoing pixel is always read from the same place.
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        bfre_pkg::cell_ctrl_t ctrl;
        logic [bfre_pkg::PIX_W-1:0] nbr;
        assign ctrl.fill  = ev_fill;
        assign ctrl.shift = ev_valid && !ev_fill;
        assign ctrl.entry = (entry_idx == IDX_W'(i));
        if (i == 0) begin : g_head
            assign nbr = ev_pix;
        end else begin : g_body
            assign nbr = cell_pix[i-1];
        end
        bfre_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .bcast_pix (ev_pix),
            .nbr_pix   (nbr),
            .pix       (cell_pix[i])
        );
    end

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        state_next  = state_reg;
        radius_next = radius_reg;
        n_next      = n_reg;
        nh_next     = nh_reg;
        k_next      = k_reg;
        hold_next   = hold_reg;
        sum_next    = sum_reg;
        v0_next     = ev_emit;
        l0_next     = ev_last;

        if (ev_fill) begin
            sum_next = bfre_pkg::SUM_W'(win_len) * bfre_pkg::SUM_W'(ev_pix);
        end else if (ev_valid) begin
            sum_next = sum_reg + bfre_pkg::SUM_W'(ev_pix)
                     - bfre_pkg::SUM_W'(cell_pix[DEPTH-1]);
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (acc) begin
                    if (s_tlast) begin
                        n_next = '0;
                        if (ar != '0) begin
                            state_next = ST_FLUSH;
                            k_next     = bfre_pkg::RAD_W'(1);
                            nh_next    = n_reg;
                            hold_next  = ev_pix;
                        end
                    end else if (n_reg != bfre_pkg::ROWPOS_W'(bfre_pkg::ROWPOS_MAX)) begin
                        n_next = n_reg + bfre_pkg::ROWPOS_W'(1);
                    end
                end
            end
            ST_FLUSH: begin
                if (flush_go) begin
                    if (k_reg == ar) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next = k_reg + bfre_pkg::RAD_W'(1);
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // a radius write abandons the row
        if (cfg_wr) begin
            radius_next = pwdata[bfre_pkg::RAD_W-1:0];
            n_next      = '0;
        end
    end

    // ---------------------------------------------------------------- mean pipeline
    bfre_mean u_mean (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (v0_reg),
        .in_last   (l0_reg),
        .in_sum    (sum_reg),
        .radius    (ar),
        .out_valid (mean_valid),
        .out_last  (mean_last),
        .out_mean  (mean_pix)
    );

    // ---------------------------------------------------------------- output queue
    always_comb begin
        pend_next = pend_reg + bfre_pkg::OUTQ_CNT_W'(ev_emit)
                  - bfre_pkg::OUTQ_CNT_W'(pop);
        qcnt_next = qcnt_reg + bfre_pkg::OUTQ_CNT_W'(mean_valid)
                  - bfre_pkg::OUTQ_CNT_W'(pop);
        wptr_next = wptr_reg + bfre_pkg::OUTQ_PTR_W'(mean_valid);
        rptr_next = rptr_reg + bfre_pkg::OUTQ_PTR_W'(pop);
    end

    assign m_tvalid = (qcnt_reg != '0);
    assign m_tdata  = qpix_reg[rptr_reg];
    assign m_tlast  = qlast_reg[rptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            radius_reg <= bfre_pkg::RAD_W'(1);
            n_reg      <= '0;
            k_reg      <= '0;
            sum_reg    <= '0;
            v0_reg     <= 1'b0;
            pend_reg   <= '0;
            qcnt_reg   <= '0;
            wptr_reg   <= '0;
            rptr_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            radius_reg <= radius_next;
            n_reg      <= n_next;
            k_reg      <= k_next;
            sum_reg    <= sum_next;
            v0_reg     <= v0_next;
            pend_reg   <= pend_next;
            qcnt_reg   <= qcnt_next;
            wptr_reg   <= wptr_next;
            rptr_reg   <= rptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        nh_reg   <= nh_next;
        hold_reg <= hold_next;
        l0_reg   <= l0_next;
        if (mean_valid) begin
            qpix_reg[wptr_reg]  <= mean_pix;
            qlast_reg[wptr_reg] <= mean_last;
        end
    end

    // ---------------------------------------------------------------- checks
    // results owed never exceed queue space
    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= bfre_pkg::OUTQ_CNT_W'(bfre_pkg::OUTQ_DEPTH))
        else $error("outstanding result count overran the output queue");

    // queued results are a subset of owed results
    a_queue_le_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        qcnt_reg <= pend_reg)
        else $error("output queue holds more than was issued");

    // a row end with nonzero radius starts a flush
    a_flush_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc && s_tlast && (ar != '0)) |=> (state_reg == ST_FLUSH))
        else $error("row end did not start the flush");

    // the final flush shift always issues the row's last result
    a_flush_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (flush_go && (k_reg == ar)) |-> (ev_emit && ev_last))
        else $error("flush ended without the last result");

endmodule

// ===== tb/sv/box_filter_row_edge_replicate_checker.sv =====
// Watches the pixel, result and register channels of the row box filter, predicts and compares.
module box_filter_row_edge_replicate_checker #(
    parameter int MAX_RADIUS = 31
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] pixel_in
    input  logic                            s_tlast,   // last_in_row
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [7:0]                      m_tdata,   // [7:0] pixel_out
    input  logic                            m_tlast,   // last_out
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bfre_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]                     pwdata,
    input  logic                            pready,
    output int                              errors,
    output int                              pending
);

    localparam int LINE_DEPTH = 2 * MAX_RADIUS + 1;

    typedef struct packed {
        logic [bfre_pkg::PIX_W-1:0] pixel;
        logic                       last;
    } blur_beat_t;

    logic [bfre_pkg::PIX_W-1:0]    line_px [LINE_DEPTH];
    logic [bfre_pkg::SUM_W-1:0]    line_sum;
    logic [bfre_pkg::ROWPOS_W-1:0] row_count;
    logic [bfre_pkg::RAD_W-1:0]    radius;
    blur_beat_t                    pending_means [$];
    blur_beat_t                    want;

    function automatic int eff_radius();
        return (radius > MAX_RADIUS) ? MAX_RADIUS : int'(radius);
    endfunction

    // newest pixel enters at entry 0, the oldest of the window leaves the sum
    task automatic push_line(input logic [7:0] p, input int depth);
        line_sum = line_sum + bfre_pkg::SUM_W'(p) - bfre_pkg::SUM_W'(line_px[depth-1]);
        for (int i = depth - 1; i > 0; i--)
            line_px[i] = line_px[i-1];
        line_px[0] = p;
    endtask

    task automatic push_mean(input int r, input logic lst);
        blur_beat_t b;
        int         mean;
        mean    = (int'(line_sum) + r) / (2 * r + 1);
        b.pixel = mean[7:0];
        b.last  = lst;
        pending_means = {pending_means, b};
    endtask

    task automatic blur_step(input logic [7:0] p, input logic lst);
        int r;
        int d;
        int n;
        r = eff_radius();
        d = 2 * r + 1;
        n = int'(row_count);
        if (n == 0) begin
            for (int i = 0; i < d; i++)
                line_px[i] = p;
            line_sum = bfre_pkg::SUM_W'(d * p);
        end else begin
            push_line(p, d);
        end
        if (n >= r)
            push_mean(r, lst && r == 0);
        if (lst) begin
            // flush: right edge repeats the last pixel
            for (int k = 1; k <= r; k++) begin
                push_line(p, d);
                if (n + k >= r)
                    push_mean(r, k == r);
            end
            row_count = '0;
        end else if (n < bfre_pkg::ROWPOS_MAX) begin
            row_count = row_count + bfre_pkg::ROWPOS_W'(1);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < LINE_DEPTH; i++)
                line_px[i] = '0;
            line_sum  = '0;
            row_count = '0;
            radius    = bfre_pkg::RAD_W'(1);
            pending_means.delete();
        end else begin
            if (psel && penable && pwrite && pready &&
                paddr[bfre_pkg::CFG_ADDR_W-1:2] == bfre_pkg::CFG_IDX_RADIUS) begin
                radius    = pwdata[bfre_pkg::RAD_W-1:0];
                row_count = '0;
            end
            if (m_tvalid && m_tready) begin
                if (pending_means.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got pixel %0d last %0b",
                             $time, m_tdata, m_tlast);
                end else begin
                    want = pending_means.pop_front();
                    if (want.pixel !== m_tdata) begin
                        errors++;
                        $display("%0t: pixel_out mismatch, expected %0d, got %0d",
                                 $time, want.pixel, m_tdata);
                    end
                    if (want.last !== m_tlast) begin
                        errors++;
                        $display("%0t: last_out mismatch, expected %0b, got %0b",
                                 $time, want.last, m_tlast);
                    end
                end
            end
            if (s_tvalid && s_tready)
                blur_step(s_tdata, s_tlast);
        end
        pending = pending_means.size();
    end

endmodule

// ===== tb/sv/box_filter_row_edge_replicate_top_tb.sv =====
// Testbench top for the row box filter: stimulus, handshake pacing and the verdict.
module box_filter_row_edge_replicate_top_tb;

    localparam int   RADIUS_MAX    = 31;
    localparam int   LIMIT         = 300000;  // cycles; far above the slowest correct run
    localparam int   SETTLE        = 80;      // covers a full flush, the mean pipe and the output queue
    localparam int   PHASES        = 10;
    localparam int   PHASE_PIXELS  = 25;
    localparam logic CFG_IDX_SPARE = 1'b1;    // unmapped register slot, writes ignored

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata  = '0;  // [7:0] pixel_in
    logic                            s_tlast  = 1'b0; // last_in_row
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [7:0]                      m_tdata;        // [7:0] pixel_out
    logic                            m_tlast;        // last_out
    logic                            psel     = 1'b0;
    logic                            penable  = 1'b0;
    logic                            pwrite   = 1'b0;
    logic [bfre_pkg::CFG_ADDR_W-1:0] paddr    = '0;
    logic [31:0]                     pwdata   = '0;
    logic [31:0]                     prdata;
    logic                            pready;

    int errors;
    int pending;
    int cycles  = 0;
    int m_wait  = 0;
    int m_draw;
    bit quiet_s = 1'b0;  // sender runs back to back while set
    bit quiet_m = 1'b0;  // receiver never stalls while set

    always #4 aclk = ~aclk;

    box_filter_row_edge_replicate_top #(
        .MAX_RADIUS (RADIUS_MAX)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    box_filter_row_edge_replicate_checker #(
        .MAX_RADIUS (RADIUS_MAX)
    ) u_blur_check (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .pready   (pready),
        .errors   (errors),
        .pending  (pending)
    );

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("[box_filter_row_edge_replicate_top] ERROR");
            $finish;
        end
    end

    // Result side back-pressure. After each accepted beat draw a random stall into
    // m_wait (none if zero); m_wait counts it down and m_tready rises on its last step.
    // quiet_m toggles now and then to give stall-free stretches.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            m_wait   <= 0;
        end else if (m_wait > 0) begin
            m_wait   <= m_wait - 1;
            m_tready <= (m_wait == 1);
        end else if (!m_tready) begin
            m_tready <= 1'b1;
        end else if (m_tvalid) begin
            if ($urandom_range(0, 31) == 0)
                quiet_m = !quiet_m;
            m_draw = quiet_m ? 0 : $urandom_range(0, 4);
            m_wait   <= m_draw;
            m_tready <= (m_draw == 0);
        end
    end

    // One pixel beat. Optional gap first (tvalid low), then hold until accepted.
    // tvalid is only lowered when a gap follows, so back-to-back beats keep it high.
    task automatic send_px(input logic [7:0] p, input logic lst);
        int gap;
        if ($urandom_range(0, 31) == 0)
            quiet_s = !quiet_s;
        gap = quiet_s ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Only bits 4:0 matter; junk in the upper bits checks they are dropped.
    task automatic set_radius(input int r);
        write_reg(bfre_pkg::CFG_IDX_RADIUS, ($urandom() & 32'hFFFF_FFE0) | 32'(r));
    endtask

    // Stop sending, wait out every predicted result, then let the flush and
    // mean pipeline run dry (beats that make no result may still be in flight).
    // pending is sampled on the falling edge, clear of the checker's update.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_px();
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // close = 0 leaves the row open, to be dropped by the next radius write
    task automatic send_row(input int len, input bit close, input bit flat);
        logic [7:0] p;
        p = pick_px();
        for (int i = 0; i < len; i++) begin
            if (!flat)
                p = pick_px();
            send_px(p, close && i == len - 1);
        end
    endtask

    int plan [7] = '{1, 0, 31, 2, 5, 31, 3};
    int r;
    int len;
    int sel;
    int sent;

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, radius 1 from reset.
        send_px(8'd0, 1'b0);
        send_px(8'd255, 1'b0);
        send_px(8'd0, 1'b0);
        send_px(8'd255, 1'b0);
        send_px(8'd128, 1'b1);
        send_px(8'd255, 1'b1);    // one-pixel row, shorter than the window
        send_px(8'd7, 1'b0);
        send_px(8'd200, 1'b1);
        send_px(8'd90, 1'b0);     // open row, abandoned by the write below
        send_px(8'd91, 1'b0);
        wait_idle();

        set_radius(0);            // pass-through
        send_px(8'd0, 1'b0);
        send_px(8'd255, 1'b0);
        send_px(8'd1, 1'b0);
        send_px(8'd254, 1'b1);
        wait_idle();

        write_reg(CFG_IDX_SPARE, 32'h0000_001F);   // must not touch the radius
        send_px(8'd170, 1'b0);
        send_px(8'd85, 1'b1);
        wait_idle();

        set_radius(RADIUS_MAX);   // widest window on rows far shorter than it
        send_px(8'd255, 1'b0);
        send_px(8'd255, 1'b0);
        send_px(8'd0, 1'b1);
        send_px(8'd255, 1'b1);
        wait_idle();

        // Random phases: fixed radius plan first (extremes included), then random.
        for (int ph = 0; ph < PHASES; ph++) begin
            r = (ph < 7) ? plan[ph] : $urandom_range(0, RADIUS_MAX);
            set_radius(r);
            sent = 0;
            if (ph % 3 == 0) begin
                // long row: row position saturates
                send_row(70, 1'b1, 1'b0);
                sent = 70;
            end
            while (sent < PHASE_PIXELS) begin
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    len = $urandom_range(1, 2 * r + 3);
                else if (sel < 9)
                    len = $urandom_range(1, 6);
                else
                    len = $urandom_range(64, 80);
                send_row(len, 1'b1, $urandom_range(0, 7) == 0);
                sent += len;
                if ($urandom_range(0, 11) == 0)
                    wait_idle();          // sender holds off until all results are in
            end
            if ($urandom_range(0, 2) == 0)
                send_row($urandom_range(1, 2 * r + 3), 1'b0, 1'b0);
            wait_idle();
        end

        @(negedge aclk);
        if (errors == 0)
            $display("[box_filter_row_edge_replicate_top] OK");
        else
            $display("[box_filter_row_edge_replicate_top] ERROR");
        $finish;
    end

endmodule
